[design/ptw_pkg.sv]
// Shared types, constants and helpers of the four-level page table walker.
`timescale 1ns / 1ps

package ptw_pkg;

    // Default log2 of the number of 64-bit words in the table memory.
    localparam int MEM_WORDS_LOG2_DEF = 16;

    localparam int PHYS_W   = 52;
    localparam int LIN_W    = 48;
    localparam int ENTRY_W  = 64;
    localparam int IDX_W    = 9;
    localparam int OFS_W    = 12;
    localparam int RADDR_W  = PHYS_W + 1;

    // Bit positions of the four table indices within the linear address.
    localparam int SHIFT_L0 = 39;
    localparam int SHIFT_L1 = 30;
    localparam int SHIFT_L2 = 21;
    localparam int SHIFT_L3 = 12;

    localparam logic [1:0] LVL_LAST = 2'd3;

    // Request kinds carried in the input side band.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_XLATE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIRST,
        ST_WALK
    } walk_state_t;

    // Status of the walk controller seen by the top level.
    typedef struct packed {
        logic              idle;
        logic              res_valid;
        logic              res_fault;
        logic [PHYS_W-1:0] res_phys;
    } walk_status_t;

    function automatic logic [IDX_W-1:0] level_index(input logic [LIN_W-1:0] la,
                                                      input logic [1:0]       lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = la[SHIFT_L0 +: IDX_W];
            2'd1:    idx = la[SHIFT_L1 +: IDX_W];
            2'd2:    idx = la[SHIFT_L2 +: IDX_W];
            default: idx = la[SHIFT_L3 +: IDX_W];
        endcase
        return idx;
    endfunction

endpackage

[design/ptw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ptw_ram #(
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // Read data holds while no read is issued.
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/ptw_walk.sv]
// Walk controller: clearing pass after reset and the four-level table walk.
`timescale 1ns / 1ps

module ptw_walk
    import ptw_pkg::*;
#(
    parameter int MEM_WORDS_LOG2 = MEM_WORDS_LOG2_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [LIN_W-1:0]          linear_addr,
    input  logic [PHYS_W-1:0]         root_base,
    input  logic                      out_free,
    input  logic [ENTRY_W-1:0]        rdata,
    output logic                      rd_en,
    output logic [MEM_WORDS_LOG2-1:0] rd_addr,
    output logic                      clr_en,
    output logic [MEM_WORDS_LOG2-1:0] clr_addr,
    output walk_status_t              status
);

    walk_state_t               state_reg, state_next;
    logic [1:0]                lvl_reg, lvl_next;
    logic [LIN_W-1:0]          la_reg;
    logic                      rd_ok_reg, rd_ok_next;
    logic [MEM_WORDS_LOG2-1:0] clr_cnt_reg, clr_cnt_next;

    logic [ENTRY_W-1:0] entry;
    logic               present;
    logic               finish;
    logic [RADDR_W-1:0] byte_addr;
    logic               addr_ok;
    logic [PHYS_W-1:0]  phys;

    // An entry read from an unaligned or out-of-range address counts as zero.
    assign entry   = rd_ok_reg ? rdata : '0;
    assign present = entry[0];
    assign finish  = !present || (lvl_reg == LVL_LAST);
    assign phys    = present ? {entry[PHYS_W-1:OFS_W], la_reg[OFS_W-1:0]} : '0;

    // The root base may be unaligned, so the first level needs a real add.
    // Later bases come from an entry with the low 12 bits clear.
    always_comb begin
        if (state_reg == ST_FIRST) begin
            byte_addr = {1'b0, root_base}
                      + {{(RADDR_W-IDX_W-3){1'b0}}, level_index(la_reg, 2'd0), 3'b000};
        end else begin
            byte_addr = {1'b0, entry[PHYS_W-1:OFS_W],
                         level_index(la_reg, lvl_reg + 2'd1), 3'b000};
        end
    end

    assign addr_ok = (byte_addr[2:0] == 3'b000)
                  && (byte_addr[RADDR_W-1:MEM_WORDS_LOG2+3] == '0);
    assign rd_addr = byte_addr[MEM_WORDS_LOG2+2:3];

    // Next state.
    always_comb begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        rd_ok_next   = rd_ok_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                lvl_next   = 2'd0;
                rd_ok_next = addr_ok;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (finish) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    lvl_next   = lvl_reg + 2'd1;
                    rd_ok_next = addr_ok;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        rd_en            = 1'b0;
        clr_en           = 1'b0;
        status.idle      = 1'b0;
        status.res_valid = 1'b0;
        status.res_fault = 1'b0;
        status.res_phys  = '0;
        case (state_reg)
            ST_CLEAR: begin
                clr_en = 1'b1;
            end
            ST_IDLE: begin
                status.idle = 1'b1;
            end
            ST_FIRST: begin
                rd_en = 1'b1;
            end
            ST_WALK: begin
                rd_en            = !finish;
                status.res_valid = finish && out_free;
                status.res_fault = !present || (phys == '0);
                status.res_phys  = phys;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign clr_addr = clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            lvl_reg     <= 2'd0;
            rd_ok_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            lvl_reg     <= lvl_next;
            rd_ok_reg   <= rd_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && (state_reg == ST_IDLE)) begin
            la_reg <= linear_addr;
        end
    end

endmodule

[design/four_level_page_table_walker_unit.sv]
// Top level of the four-level page table walker.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       s_tuser: req_type; s_tdata: mem_addr,
//                                                mem_data, linear_addr
// m_        out        m_tvalid / m_tready       m_tuser: fault; m_tdata: phys_addr
// cfg_      in         cfg_valid / cfg_ready     cfg_data: root_table_base
//
// A write word lands in the table memory at the edge that accepts it.
// A translate word makes four dependent reads of the table memory when all four
// levels are walked: ST_FIRST reads the root-level entry, each ST_WALK step reads
// the next level from the registered read data, and the last level forms the result.
// A walk that hits a non-present entry ends early and forms its result at that level.
// After reset the block sweeps all 2**MEM_WORDS_LOG2 words of the table memory (65536
// by default) to zero, one word per cycle, and s_tready stays low until then.
// The result sits in an output register; the walker only stalls at the end of a
// walk when that register is still full and m_tready is low. Configuration writes
// are taken in every cycle.

module four_level_page_table_walker_unit
    import ptw_pkg::*;
#(
    parameter int MEM_WORDS_LOG2 = MEM_WORDS_LOG2_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [0:0]   s_tuser,   // [0] req_type
    input  logic [167:0] s_tdata,   // [51:0] mem_addr, [115:52] mem_data,
                                    // [163:116] linear_addr, [167:164] zero

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [0:0]   m_tuser,   // [0] fault
    output logic [55:0]  m_tdata,   // [51:0] phys_addr, [55:52] zero

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [51:0]  cfg_data   // [51:0] root_table_base
);

    localparam int ADDR_LSB = 0;
    localparam int DATA_LSB = ADDR_LSB + PHYS_W;
    localparam int LIN_LSB  = DATA_LSB + ENTRY_W;

    logic [PHYS_W-1:0]  in_mem_addr;
    logic [ENTRY_W-1:0] in_mem_data;
    logic [LIN_W-1:0]   in_linear_addr;
    logic               accept;
    logic               start;
    logic               wr_hit;

    logic [PHYS_W-1:0]  root_reg;
    logic               m_tvalid_reg;
    logic               fault_reg;
    logic [PHYS_W-1:0]  phys_reg;
    logic               out_free;

    walk_status_t              status;
    logic                      rd_en;
    logic [MEM_WORDS_LOG2-1:0] rd_addr;
    logic                      clr_en;
    logic [MEM_WORDS_LOG2-1:0] clr_addr;
    logic [ENTRY_W-1:0]        rdata;

    logic                      ram_we;
    logic [MEM_WORDS_LOG2-1:0] ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;

    assign in_mem_addr    = s_tdata[ADDR_LSB +: PHYS_W];
    assign in_mem_data    = s_tdata[DATA_LSB +: ENTRY_W];
    assign in_linear_addr = s_tdata[LIN_LSB +: LIN_W];

    // Only the idle walker takes words; a waiting result does not block it.
    assign s_tready = status.idle;
    assign accept   = s_tvalid && s_tready;
    assign start    = accept && (s_tuser[0] == REQ_XLATE);

    // Writes to an unaligned address or beyond the memory are dropped.
    assign wr_hit = accept && (s_tuser[0] == REQ_WRITE)
                 && (in_mem_addr[2:0] == 3'b000)
                 && (in_mem_addr[PHYS_W-1:MEM_WORDS_LOG2+3] == '0);

    // The clearing pass owns the write port while it runs; no words are taken then.
    always_comb begin
        if (clr_en) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = wr_hit;
            ram_waddr = in_mem_addr[MEM_WORDS_LOG2+2:3];
            ram_wdata = in_mem_data;
        end
    end

    ptw_ram #(
        .WIDTH  (ENTRY_W),
        .ADDR_W (MEM_WORDS_LOG2)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    ptw_walk #(
        .MEM_WORDS_LOG2 (MEM_WORDS_LOG2)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .linear_addr (in_linear_addr),
        .root_base   (root_reg),
        .out_free    (out_free),
        .rdata       (rdata),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .clr_en      (clr_en),
        .clr_addr    (clr_addr),
        .status      (status)
    );

    // Root table base register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            root_reg <= cfg_data;
        end
    end

    // Output register: free when empty or being taken in this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (status.res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (status.res_valid) begin
            fault_reg <= status.res_fault;
            phys_reg  <= status.res_fault ? '0 : status.res_phys;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = fault_reg;
    assign m_tdata  = {4'b0000, phys_reg};

endmodule

[design/ptw_checker.sv]
// Port-level checker of the page table walker and its bind statement.
`timescale 1ns / 1ps

module ptw_checker
    import ptw_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [0:0]   m_tuser,
    input logic [55:0]  m_tdata
);

    // A translation occupies the walker for at least the next cycle.
    a_walk_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == REQ_XLATE)) |=> !s_tready)
        else $error("input taken right after a translate word");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // A good translation never yields address zero.
    a_ok_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata != '0))
        else $error("successful translation with zero address");

    // A fault reports address zero.
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("faulting translation with nonzero address");

endmodule

bind four_level_page_table_walker_unit ptw_checker u_ptw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

[sim/testbench.sv]
// Self-checking testbench that walks page tables through the four-level walker unit.
`timescale 1ns / 1ps

import ptw_pkg::*;

localparam int TABLE_WORDS = 1 << MEM_WORDS_LOG2_DEF;
localparam int TABLE_FRAMES = TABLE_WORDS * 8 / 4096;

typedef struct packed {
    logic              kind;
    logic [PHYS_W-1:0] addr;
    logic [ENTRY_W-1:0] data;
    logic [LIN_W-1:0]  la;
} walk_req_t;

typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic              fault;
} xlate_result_t;

// Table index that a linear address selects at one level, level 0 being the root.
function automatic logic [IDX_W-1:0] index_at(input logic [LIN_W-1:0] la, input int lvl);
    return IDX_W'(la >> (SHIFT_L0 - IDX_W * lvl));
endfunction

// Keeps its own copy of the table memory and the root base, works out the
// translation of every accepted translate word and holds it until the block answers.
class page_walk_checker;
    logic [ENTRY_W-1:0] table_words [0:TABLE_WORDS-1];
    logic [PHYS_W-1:0]  root_base;
    xlate_result_t      expected_xlates [$];
    int unsigned        failures;

    function new();
        for (int i = 0; i < TABLE_WORDS; i++) begin
            table_words[i] = '0;
        end
        root_base = '0;
        failures = 0;
    endfunction

    function void set_root(input logic [PHYS_W-1:0] value);
        root_base = value;
    endfunction

    function int unsigned pending();
        return expected_xlates.size();
    endfunction

    // Unaligned or out-of-range reads see an empty entry.
    function logic [ENTRY_W-1:0] read_entry(input logic [63:0] byte_addr);
        if (byte_addr[2:0] != 3'd0 || byte_addr[63:3] >= TABLE_WORDS) begin
            return '0;
        end
        return table_words[byte_addr[63:3]];
    endfunction

    function void take_request(input walk_req_t req);
        logic [63:0]        base;
        logic [ENTRY_W-1:0] entry;
        logic [63:0]        pa;
        logic               flt;
        int                 lvl;
        xlate_result_t      res;
        if (req.kind == REQ_WRITE) begin
            if (req.addr[2:0] == 3'd0 && req.addr[PHYS_W-1:3] < TABLE_WORDS) begin
                table_words[req.addr[PHYS_W-1:3]] = req.data;
            end
            return;
        end
        base = {12'd0, root_base};
        flt = 1'b0;
        lvl = 0;
        while (lvl < 4 && !flt) begin
            entry = read_entry(base + 64'(index_at(req.la, lvl)) * 64'd8);
            if (!entry[0]) begin
                flt = 1'b1;
            end else begin
                base = {12'd0, entry[51:12], 12'd0};
            end
            lvl++;
        end
        pa = flt ? 64'd0 : ((base + 64'(req.la[OFS_W-1:0])) & ((64'd1 << PHYS_W) - 64'd1));
        if (pa == 64'd0) begin
            flt = 1'b1;
        end
        res.phys = pa[PHYS_W-1:0];
        res.fault = flt;
        expected_xlates.insert(expected_xlates.size(), res);
    endfunction

    function void check_translation(input logic [PHYS_W-1:0] phys, input logic flt);
        xlate_result_t exp_res;
        if (expected_xlates.size() == 0) begin
            $display("%0t: unexpected result word, phys_addr %h fault %0d", $time, phys, flt);
            failures++;
            return;
        end
        exp_res = expected_xlates.pop_front();
        if (exp_res.phys !== phys) begin
            $display("%0t: phys_addr mismatch, expected %h actual %h",
                     $time, exp_res.phys, phys);
            failures++;
        end
        if (exp_res.fault !== flt) begin
            $display("%0t: fault mismatch, expected %0d actual %0d",
                     $time, exp_res.fault, flt);
            failures++;
        end
    endfunction
endclass

module testbench;

    // Margin that covers a full walk plus the output register.
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 500;
    localparam int CYCLE_LIMIT  = 1000000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [0:0]   s_tuser;
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [0:0]   m_tuser;
    logic [55:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [51:0]  cfg_data;

    page_walk_checker  sb;
    logic [PHYS_W-1:0] root_now;
    int unsigned       burst_left;
    int unsigned       items_done;
    bit                offering;
    bit                fill_up;
    int unsigned       cycle_count = 0;

    four_level_page_table_walker_unit #(
        .MEM_WORDS_LOG2 (MEM_WORDS_LOG2_DEF)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL four_level_page_table_walker_unit");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_translation(m_tdata[PHYS_W-1:0], m_tuser[0]);
        end
    end

    // The receiver runs stretches of steady or stalling behavior; once the main
    // stimulus asks for it, it holds off long enough for the block to back up.
    initial begin : receiver
        int unsigned stretch;
        int unsigned stall_pct;
        bit          hold_done;
        m_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            if (fill_up && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stretch = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 70;
                    default: stall_pct = 95;
                endcase
                repeat (stretch) begin
                    m_tready <= ($urandom_range(0, 99) >= stall_pct);
                    @(posedge aclk);
                end
            end
        end
    end

    // Offers one word and waits for it to be taken. Words go out in bursts;
    // a burst that ends drops tvalid for a random gap.
    task automatic send_word(input logic kind, input logic [PHYS_W-1:0] addr,
                             input logic [ENTRY_W-1:0] data, input logic [LIN_W-1:0] la);
        walk_req_t req;
        req.kind = kind;
        req.addr = addr;
        req.data = data;
        req.la = la;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, la, data, addr};
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.take_request(req);
        if (kind == REQ_XLATE || (addr[2:0] == 3'd0 && addr[PHYS_W-1:3] < TABLE_WORDS)) begin
            items_done++;
        end
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic stop_offering();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        burst_left = 0;
    endtask

    // The root base is only changed once every translation has come back.
    task automatic write_root(input logic [PHYS_W-1:0] value);
        stop_offering();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_root(value);
        root_now = value;
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [PHYS_W-1:0]  phase_roots [8];
        int unsigned        phase_items [8];
        logic [LIN_W-1:0]   mapped_las [$];
        logic [63:0]        rnd;
        logic [63:0]        tbl;
        logic [ENTRY_W-1:0] ent;
        logic [LIN_W-1:0]   la;
        int unsigned        pick;
        int unsigned        bit_pos;

        sb = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        root_now  = '0;
        burst_left = 0;
        items_done = 0;
        offering  = 1'b0;
        fill_up   = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walks under a root table at 0x1000.
        write_root(52'h1000);
        send_word(REQ_XLATE, '0, '0, 48'h0);
        send_word(REQ_WRITE, 52'h1001, 64'h2001, '0);
        send_word(REQ_WRITE, 52'h80000, 64'h2001, '0);
        send_word(REQ_WRITE, 52'hF_FFFF_FFFF_FFF8, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_word(REQ_XLATE, '0, '0, 48'h0);
        // All-ones linear address through the last entry of each table.
        send_word(REQ_WRITE, 52'h1FF8, 64'h2001, '0);
        send_word(REQ_WRITE, 52'h2FF8, 64'h3001, '0);
        send_word(REQ_WRITE, 52'h3FF8, 64'h4001, '0);
        send_word(REQ_WRITE, 52'h4FF8, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_word(REQ_XLATE, '0, '0, 48'hFFFF_FFFF_FFFF);
        // Not present at the second level, then a walk that lands on address zero.
        send_word(REQ_WRITE, 52'h1000, 64'h5001, '0);
        send_word(REQ_XLATE, '0, '0, 48'h0);
        send_word(REQ_WRITE, 52'h5000, 64'h6001, '0);
        send_word(REQ_WRITE, 52'h6000, 64'h7001, '0);
        send_word(REQ_WRITE, 52'h7000, 64'h1, '0);
        send_word(REQ_XLATE, '0, '0, 48'h0);
        send_word(REQ_XLATE, '0, '0, 48'h123);
        // A next table beyond the memory reads as empty.
        send_word(REQ_WRITE, 52'h1008, 64'h000F_FFFF_FFFF_F001, '0);
        send_word(REQ_XLATE, '0, '0, 48'h1 << 39);
        // Not present at the leaf level.
        send_word(REQ_WRITE, 52'h7008, 64'h8000, '0);
        send_word(REQ_XLATE, '0, '0, 48'h1 << 12);
        // Leaf table in the last frame, leaf entry in the last word of the memory.
        send_word(REQ_WRITE, 52'h6008, 64'h7F001, '0);
        send_word(REQ_WRITE, 52'h7FFF8, 64'hABCD_E001, '0);
        send_word(REQ_XLATE, '0, '0, (48'h1 << 21) | (48'h1FF << 12) | 48'hFFF);

        phase_roots[0] = '0;
        phase_roots[1] = 52'hF_FFFF_FFFF_FFFF;
        phase_roots[2] = PHYS_W'((TABLE_FRAMES - 1) * 4096);
        phase_roots[3] = PHYS_W'($urandom_range(0, TABLE_FRAMES - 1) * 4096);
        phase_roots[4] = PHYS_W'($urandom_range(0, TABLE_WORDS - 1) * 8);
        phase_roots[5] = PHYS_W'($urandom_range(0, TABLE_FRAMES - 1) * 4096 + 5);
        rnd = {$urandom, $urandom};
        phase_roots[6] = rnd[PHYS_W-1:0];
        phase_roots[7] = PHYS_W'($urandom_range(0, TABLE_FRAMES - 1) * 4096);
        phase_items = '{330, 60, 330, 330, 330, 80, 60, 330};

        for (int ph = 0; ph < 8; ph++) begin
            write_root(phase_roots[ph]);
            mapped_las.delete();
            items_done = 0;
            // Let the receiver back up the block while the sender keeps offering.
            if (ph == 3) begin
                fill_up = 1'b1;
            end
            while (items_done < phase_items[ph]) begin
                pick = $urandom_range(0, 99);
                rnd = {$urandom, $urandom};
                if (pick < 20) begin
                    // Build a full walk for a random linear address, mostly
                    // through tables that sit inside the memory.
                    la = rnd[LIN_W-1:0];
                    tbl = {12'd0, root_now};
                    for (int lvl = 0; lvl < 4; lvl++) begin
                        ent = {$urandom, $urandom};
                        if (lvl < 3 && $urandom_range(0, 9) != 0) begin
                            ent[51:12] = 40'($urandom_range(0, TABLE_FRAMES - 1));
                        end
                        ent[0] = ($urandom_range(0, 19) != 0);
                        tbl = tbl + 64'(index_at(la, lvl)) * 64'd8;
                        send_word(REQ_WRITE, tbl[PHYS_W-1:0], ent, rnd[63:16]);
                        tbl = {12'd0, ent[51:12], 12'd0};
                    end
                    mapped_las.insert(mapped_las.size(), la);
                    if (mapped_las.size() > 64) begin
                        void'(mapped_las.pop_front());
                    end
                end else if (pick < 75 && mapped_las.size() != 0) begin
                    la = mapped_las[$urandom_range(0, mapped_las.size() - 1)];
                    la[OFS_W-1:0] = rnd[OFS_W-1:0];
                    if ($urandom_range(0, 9) == 0) begin
                        bit_pos = $urandom_range(SHIFT_L3, LIN_W - 1);
                        la[bit_pos] = ~la[bit_pos];
                    end
                    send_word(REQ_XLATE, rnd[63:12], {$urandom, $urandom}, la);
                end else if (pick < 88) begin
                    // Stray writes: anywhere in the address space, or inside
                    // the memory with random alignment.
                    if ($urandom_range(0, 1) == 0) begin
                        tbl = {$urandom, $urandom};
                    end else begin
                        tbl = 64'($urandom_range(0, TABLE_WORDS * 8 - 1));
                    end
                    send_word(REQ_WRITE, tbl[PHYS_W-1:0], rnd,
                              LIN_W'({$urandom, $urandom}));
                end else begin
                    send_word(REQ_XLATE, PHYS_W'({$urandom, $urandom}),
                              {$urandom, $urandom}, rnd[LIN_W-1:0]);
                end
            end
        end

        stop_offering();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2 * DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS four_level_page_table_walker_unit");
        end else begin
            $display("FAIL four_level_page_table_walker_unit");
        end
        $finish;
    end

endmodule
